@@ src/cpsp_pkg.sv @@
// Shared types and constants of the cascaded position and speed PI controller.
// Used by cpsp_cdiv and cascaded_position_speed_pi; depends on nothing.
`default_nettype none
package cpsp_pkg;

  localparam int FIELD_W   = 32;
  localparam int GAIN_W    = 32;
  localparam int VCMD_W    = 21;
  localparam int QDRV_W    = 20;
  localparam int CFG_IDX_W = 8;

  localparam int GAIN_BITS     = 24;
  localparam int POS_INT_UNITS = 3000;
  localparam int CMD_UNITS     = 10;
  localparam int SPD_INT_UNITS = 100000;
  localparam int DRV_UNITS     = 7;
  localparam int INC_LIM_BITS  = 50;
  localparam int KI_DIV        = 1000;
  localparam int REM_W         = $clog2(KI_DIV);

  localparam logic [CFG_IDX_W-1:0] REG_POSITION_KP = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_KI = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_KP    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_KI    = 8'd3;

  localparam logic [GAIN_W-1:0] POSITION_KP_RST = 32'd16777216;
  localparam logic [GAIN_W-1:0] POSITION_KI_RST = 32'd0;
  localparam logic [GAIN_W-1:0] SPEED_KP_RST    = 32'd671089;
  localparam logic [GAIN_W-1:0] SPEED_KI_RST    = 32'd13422;

  typedef struct packed {
    logic signed [FIELD_W-1:0] target_position;
    logic signed [FIELD_W-1:0] measured_position;
    logic signed [FIELD_W-1:0] measured_velocity;
  } in_item_t;

  typedef struct packed {
    logic signed [VCMD_W-1:0] velocity_command;
    logic signed [QDRV_W-1:0] quadrature_drive;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POS_P,
    ST_POS_PW,
    ST_POS_I,
    ST_POS_IW,
    ST_CMD,
    ST_SERR,
    ST_SPD_P,
    ST_SPD_PW,
    ST_SPD_I,
    ST_SPD_IW,
    ST_DIV,
    ST_INC,
    ST_DRV,
    ST_OUT
  } cpsp_state_t;

endpackage
`default_nettype wire

@@ src/cpsp_smul.sv @@
// Bit-serial signed by unsigned multiplier, one gain bit per cycle.
// Depends on nothing beyond its parameters.
`default_nettype none
module cpsp_smul #(
  parameter int A_W = 34,
  parameter int K_W = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [A_W-1:0]   a,
  input  wire logic        [K_W-1:0]   k,
  output logic                         done,
  output logic signed [A_W+K_W:0]      prod
);

  localparam int CNT_W = $clog2(K_W);

  logic signed [A_W-1:0] a_r;
  logic        [K_W-1:0] k_r, k_nxt;
  logic signed [A_W:0]   hi_r, hi_nxt, sum;
  logic        [K_W-1:0] lo_r, lo_nxt;
  logic        [CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    sum      = hi_r + (k_r[0] ? (A_W+1)'(a_r) : '0);
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    k_nxt    = k_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      hi_nxt   = '0;
      lo_nxt   = '0;
      k_nxt    = k;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      hi_nxt  = sum >>> 1;
      lo_nxt  = {sum[0], lo_r[K_W-1:1]};
      k_nxt   = k_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(K_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
    end
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    k_r  <= k_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign prod = {hi_r, lo_r};

endmodule
`default_nettype wire

@@ src/cpsp_cdiv.sv @@
// Bit-serial restoring divider by the constant integral divisor, one
// quotient bit per cycle. Depends on cpsp_pkg.
`default_nettype none
module cpsp_cdiv
  import cpsp_pkg::*;
#(
  parameter int N_W = 67
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [N_W-1:0] dividend,
  output logic                done,
  output logic [N_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(N_W);

  logic [N_W-1:0]   q_r, q_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [REM_W:0]   trial;
  logic [REM_W-1:0] diff;
  logic             ge;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    trial    = {rem_r, q_r[N_W-1]};
    diff     = REM_W'(trial - (REM_W+1)'(KI_DIV));
    ge       = trial >= (REM_W+1)'(KI_DIV);
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[N_W-2:0], ge};
      rem_nxt = ge ? diff : trial[REM_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(N_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
`default_nettype wire

@@ src/cascaded_position_speed_pi.sv @@
// Takes a new item only in the idle state, after the previous result has been
// loaded into the output register. The time per item is set by the 32-step
// bit-serial multiplier, used four times per item, and the bit-serial divide by
// 1000, one step per product bit (MUL_W = 34 at FRAC_BITS = 16).
// Synchronous active-low reset restores the gain registers to their defaults
// and clears the integrals, the drive state and the result valid flag.
`default_nettype none
module cascaded_position_speed_pi
  import cpsp_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [GAIN_W-1:0]    cfg_data
);

  localparam longint POS_LIM = longint'(POS_INT_UNITS) << FRAC_BITS;
  localparam longint CMD_LIM = longint'(CMD_UNITS) << FRAC_BITS;
  localparam longint SI_LIM  = longint'(SPD_INT_UNITS) << FRAC_BITS;
  localparam longint DRV_LIM = longint'(DRV_UNITS) << FRAC_BITS;
  localparam longint INC_LIM = longint'(1) << INC_LIM_BITS;

  localparam int ERR_W  = FIELD_W + 1;
  localparam int PI_W   = $clog2(POS_LIM + 1) + 1;
  localparam int CMD_W  = $clog2(CMD_LIM + 1) + 1;
  localparam int SI_W   = $clog2(SI_LIM + 1) + 1;
  localparam int DRV_W  = $clog2(DRV_LIM + 1) + 1;
  localparam int INC_W  = INC_LIM_BITS + 2;
  localparam int MUL_W  = (SI_W > ERR_W) ? SI_W : ERR_W;
  localparam int PROD_W = MUL_W + GAIN_W + 1;
  localparam int SUM_W  = PROD_W + 1;

  localparam logic signed [SUM_W-1:0]   CMD_HI_S = SUM_W'(CMD_LIM);
  localparam logic signed [SUM_W-1:0]   CMD_LO_S = SUM_W'(-CMD_LIM);
  localparam logic signed [SUM_W-1:0]   INC_HI_S = SUM_W'(INC_LIM);
  localparam logic signed [SUM_W-1:0]   INC_LO_S = SUM_W'(-INC_LIM);
  localparam logic signed [MUL_W:0]     PI_HI_S  = (MUL_W+1)'(POS_LIM);
  localparam logic signed [MUL_W:0]     PI_LO_S  = (MUL_W+1)'(-POS_LIM);
  localparam logic signed [MUL_W:0]     SI_HI_S  = (MUL_W+1)'(SI_LIM);
  localparam logic signed [MUL_W:0]     SI_LO_S  = (MUL_W+1)'(-SI_LIM);
  localparam logic signed [INC_W:0]     DRV_HI_S = (INC_W+1)'(DRV_LIM);
  localparam logic signed [INC_W:0]     DRV_LO_S = (INC_W+1)'(-DRV_LIM);

  cpsp_state_t state_r, state_nxt;

  logic [GAIN_W-1:0] pkp_r, pki_r, skp_r, ski_r;

  logic signed [ERR_W-1:0]   err_r, err_nxt, serr_r, serr_nxt;
  logic signed [FIELD_W-1:0] vel_r, vel_nxt;
  logic signed [PI_W-1:0]    pint_r, pint_nxt;
  logic signed [SI_W-1:0]    sint_r, sint_nxt, sint_abs;
  logic signed [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic signed [DRV_W-1:0]   so_r, so_nxt;
  logic signed [INC_W-1:0]   inc_r, inc_nxt;
  logic signed [SUM_W-1:0]   acc_r, acc_nxt, acc_sh, iterm;
  logic signed [MUL_W:0]     pint_sum, sint_sum;
  logic signed [INC_W:0]     so_sum;

  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_data_r, out_data_nxt;

  logic                      in_xfer;
  logic                      mul_start, mul_done, div_start, div_done;
  logic signed [MUL_W-1:0]   mul_a;
  logic [GAIN_W-1:0]         mul_k;
  logic signed [PROD_W-1:0]  mul_prod;
  logic [PROD_W-1:0]         div_q;

  cpsp_smul #(
    .A_W (MUL_W),
    .K_W (GAIN_W)
  ) u_smul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .k     (mul_k),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  cpsp_cdiv #(
    .N_W (PROD_W)
  ) u_cdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mul_prod),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_POS_P;
      ST_POS_P:  state_nxt = ST_POS_PW;
      ST_POS_PW: if (mul_done) state_nxt = ST_POS_I;
      ST_POS_I:  state_nxt = ST_POS_IW;
      ST_POS_IW: if (mul_done) state_nxt = ST_CMD;
      ST_CMD:    state_nxt = ST_SERR;
      ST_SERR:   state_nxt = ST_SPD_P;
      ST_SPD_P:  state_nxt = ST_SPD_PW;
      ST_SPD_PW: if (mul_done) state_nxt = ST_SPD_I;
      ST_SPD_I:  state_nxt = ST_SPD_IW;
      ST_SPD_IW: if (mul_done) state_nxt = ST_DIV;
      ST_DIV:    if (div_done) state_nxt = ST_INC;
      ST_INC:    state_nxt = ST_DRV;
      ST_DRV:    state_nxt = ST_OUT;
      ST_OUT:    if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    sint_abs  = sint_r[SI_W-1] ? -sint_r : sint_r;
    in_ready  = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = MUL_W'(err_r);
    mul_k     = pkp_r;
    case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_POS_P: begin
        mul_start = 1'b1;
      end
      ST_POS_I: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'(pint_r);
        mul_k     = pki_r;
      end
      ST_SPD_P: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'(serr_r);
        mul_k     = skp_r;
      end
      ST_SPD_I: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'(sint_abs);
        mul_k     = ski_r;
      end
      ST_SPD_IW: div_start = mul_done;
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    err_nxt       = err_r;
    vel_nxt       = vel_r;
    serr_nxt      = serr_r;
    pint_nxt      = pint_r;
    sint_nxt      = sint_r;
    cmd_nxt       = cmd_r;
    so_nxt        = so_r;
    inc_nxt       = inc_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    acc_sh   = acc_r >>> GAIN_BITS;
    iterm    = sint_r[SI_W-1] ? -SUM_W'({1'b0, div_q}) : SUM_W'({1'b0, div_q});
    pint_sum = (MUL_W+1)'(pint_r) + (MUL_W+1)'(err_r);
    sint_sum = (MUL_W+1)'(sint_r) + (MUL_W+1)'(serr_r);
    so_sum   = (INC_W+1)'(so_r) + (INC_W+1)'(inc_r);

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          err_nxt = ERR_W'(in_data.target_position) - ERR_W'(in_data.measured_position);
          vel_nxt = in_data.measured_velocity;
        end
      end
      ST_POS_PW, ST_SPD_PW: begin
        if (mul_done) acc_nxt = SUM_W'(mul_prod);
      end
      ST_POS_IW: begin
        if (mul_done) acc_nxt = acc_r + SUM_W'(mul_prod);
      end
      ST_CMD: begin
        if (acc_sh > CMD_HI_S) begin
          cmd_nxt = CMD_W'(CMD_LIM);
        end else if (acc_sh < CMD_LO_S) begin
          cmd_nxt = CMD_W'(-CMD_LIM);
        end else begin
          cmd_nxt = acc_sh[CMD_W-1:0];
        end
        if (pint_sum > PI_HI_S) begin
          pint_nxt = PI_W'(POS_LIM);
        end else if (pint_sum < PI_LO_S) begin
          pint_nxt = PI_W'(-POS_LIM);
        end else begin
          pint_nxt = pint_sum[PI_W-1:0];
        end
      end
      ST_SERR: begin
        serr_nxt = ERR_W'(cmd_r) - ERR_W'(vel_r);
      end
      ST_DIV: begin
        if (div_done) acc_nxt = acc_r + iterm;
      end
      ST_INC: begin
        if (acc_sh > INC_HI_S) begin
          inc_nxt = INC_W'(INC_LIM);
        end else if (acc_sh < INC_LO_S) begin
          inc_nxt = INC_W'(-INC_LIM);
        end else begin
          inc_nxt = acc_sh[INC_W-1:0];
        end
      end
      ST_DRV: begin
        if (so_sum > DRV_HI_S) begin
          so_nxt = DRV_W'(DRV_LIM);
        end else if (so_sum < DRV_LO_S) begin
          so_nxt = DRV_W'(-DRV_LIM);
        end else begin
          so_nxt = so_sum[DRV_W-1:0];
        end
        if (sint_sum > SI_HI_S) begin
          sint_nxt = SI_W'(SI_LIM);
        end else if (sint_sum < SI_LO_S) begin
          sint_nxt = SI_W'(-SI_LIM);
        end else begin
          sint_nxt = sint_sum[SI_W-1:0];
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.velocity_command = VCMD_W'(cmd_r);
          out_data_nxt.quadrature_drive = QDRV_W'(so_r);
        end
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    err_r      <= err_nxt;
    vel_r      <= vel_nxt;
    serr_r     <= serr_nxt;
    cmd_r      <= cmd_nxt;
    inc_r      <= inc_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pint_r      <= '0;
      sint_r      <= '0;
      so_r        <= '0;
      pkp_r       <= POSITION_KP_RST;
      pki_r       <= POSITION_KI_RST;
      skp_r       <= SPEED_KP_RST;
      ski_r       <= SPEED_KI_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pint_r      <= pint_nxt;
      sint_r      <= sint_nxt;
      so_r        <= so_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_POSITION_KP) pkp_r <= cfg_data;
        if (cfg_index == REG_POSITION_KI) pki_r <= cfg_data;
        if (cfg_index == REG_SPEED_KP)    skp_r <= cfg_data;
        if (cfg_index == REG_SPEED_KI)    ski_r <= cfg_data;
      end
    end
  end

endmodule
`default_nettype wire

@@ bench/cascaded_position_speed_pi_tb.sv @@
// Self-checking testbench for the cascaded position and speed PI controller.
// Depends on src/cpsp_pkg.sv and src/cascaded_position_speed_pi.sv; a tracker
// class predicts each command and drive and checks them in order.
`timescale 1ns / 1ps
module cascaded_position_speed_pi_tb;
  import cpsp_pkg::*;

  localparam int FRAC = 16;
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int REPORT_CAP = 200;

  typedef logic signed [127:0] wide_t;

  localparam wide_t CMD_LIM     = wide_t'(CMD_UNITS) <<< FRAC;
  localparam wide_t POS_INT_LIM = wide_t'(POS_INT_UNITS) <<< FRAC;
  localparam wide_t DRV_LIM     = wide_t'(DRV_UNITS) <<< FRAC;
  localparam wide_t SPD_INT_LIM = wide_t'(SPD_INT_UNITS) <<< FRAC;
  localparam wide_t INC_LIM     = wide_t'(1) <<< INC_LIM_BITS;

  localparam logic [FIELD_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [FIELD_W-1:0] Q_MIN = 32'h8000_0000;

  class pi_loop_tracker;
    logic [GAIN_W-1:0] pos_kp, pos_ki, spd_kp, spd_ki;
    wide_t pos_sum, spd_sum, drive;
    out_item_t expected_results[$];
    int mismatch_count;

    function new();
      pos_kp = POSITION_KP_RST;
      pos_ki = POSITION_KI_RST;
      spd_kp = SPEED_KP_RST;
      spd_ki = SPEED_KI_RST;
      pos_sum = 0;
      spd_sum = 0;
      drive = 0;
      mismatch_count = 0;
    endfunction

    function wide_t clamp_to(wide_t x, wide_t lim);
      if (x > lim) return lim;
      if (x < -lim) return -lim;
      return x;
    endfunction

    function wide_t gain_w(logic [GAIN_W-1:0] g);
      return $signed({96'b0, g});
    endfunction

    function void set_gain(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
      case (idx)
        REG_POSITION_KP: pos_kp = val;
        REG_POSITION_KI: pos_ki = val;
        REG_SPEED_KP: spd_kp = val;
        REG_SPEED_KI: spd_ki = val;
        default: ;
      endcase
    endfunction

    function void note_tick(in_item_t item);
      wide_t err, cmd, serr, mag, iterm, inc;
      out_item_t want;
      err = $signed(item.target_position);
      err = err - $signed(item.measured_position);
      cmd = clamp_to((err * gain_w(pos_kp) + pos_sum * gain_w(pos_ki)) >>> GAIN_BITS, CMD_LIM);
      pos_sum = clamp_to(pos_sum + err, POS_INT_LIM);
      serr = cmd - $signed(item.measured_velocity);
      mag = (spd_sum < 0) ? -spd_sum : spd_sum;
      iterm = (mag * gain_w(spd_ki)) / KI_DIV;
      if (spd_sum < 0) iterm = -iterm;
      inc = clamp_to((serr * gain_w(spd_kp) + iterm) >>> GAIN_BITS, INC_LIM);
      drive = clamp_to(drive + inc, DRV_LIM);
      spd_sum = clamp_to(spd_sum + serr, SPD_INT_LIM);
      want.velocity_command = cmd[VCMD_W-1:0];
      want.quadrature_drive = drive[QDRV_W-1:0];
      expected_results.push_back(want);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
          $display("%0t: unexpected result, velocity_command %0d, quadrature_drive %0d",
                   $time, got.velocity_command, got.quadrature_drive);
        return;
      end
      want = expected_results.pop_front();
      if (got.velocity_command !== want.velocity_command) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
          $display("%0t: velocity_command expected %0d, actual %0d",
                   $time, want.velocity_command, got.velocity_command);
      end
      if (got.quadrature_drive !== want.quadrature_drive) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
          $display("%0t: quadrature_drive expected %0d, actual %0d",
                   $time, want.quadrature_drive, got.quadrature_drive);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GAIN_W-1:0] cfg_data;

  pi_loop_tracker tracker;
  int ticks_accepted = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  logic [FIELD_W-1:0] track_target = '0;

  cascaded_position_speed_pi #(.FRAC_BITS(FRAC)) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tracker.set_gain(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        tracker.note_tick(in_data);
        ticks_accepted++;
      end
      if (out_valid && out_ready) tracker.check_result(out_data);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("cascaded_position_speed_pi test failed");
      $finish;
    end
  end

  initial begin
    int rcv_mode;
    int mode_left;
    bit long_hold_done;
    rcv_mode = 0;
    mode_left = 0;
    long_hold_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!long_hold_done && ticks_accepted >= 400) begin
        out_ready <= 1'b0;
        repeat (1500) @(posedge clk);
        long_hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        rcv_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(32, 400);
      end
      mode_left--;
      case (rcv_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  function automatic in_item_t tick_of(logic [FIELD_W-1:0] t, logic [FIELD_W-1:0] m,
                                       logic [FIELD_W-1:0] v);
    in_item_t it;
    it.target_position = t;
    it.measured_position = m;
    it.measured_velocity = v;
    return it;
  endfunction

  function automatic logic [FIELD_W-1:0] rand_field(int kind);
    case (kind)
      0: return $urandom_range(0, 8191) - 4096;
      1: return $urandom_range(0, 40 << 16) - (20 << 16);
      2: return $urandom;
      default: begin
        case ($urandom_range(0, 4))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return '0;
          3: return 32'd1;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  function automatic in_item_t random_tick();
    in_item_t it;
    int style;
    style = $urandom_range(0, 19);
    if (style < 10) begin
      if ($urandom_range(0, 15) == 0)
        track_target = $urandom_range(0, 1) ? rand_field(2) : rand_field(1);
      it.target_position = track_target;
      it.measured_position = track_target - rand_field($urandom_range(0, 1));
      it.measured_velocity = rand_field($urandom_range(0, 1));
    end else if (style < 15) begin
      it = tick_of(rand_field($urandom_range(0, 3)), rand_field($urandom_range(0, 3)),
                   rand_field($urandom_range(0, 3)));
    end else if (style < 18) begin
      it = tick_of(rand_field(2), rand_field(2), rand_field(2));
    end else begin
      it = tick_of(rand_field(3), rand_field(3), rand_field(3));
    end
    return it;
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return (1 << 24) + $urandom_range(0, 1 << 22) - (1 << 21);
      3: return $urandom_range(0, 1 << 25);
      4: return $urandom_range(0, 1 << 20);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_tick(input in_item_t item);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.expected_results.size() != 0);
  endtask

  initial begin
    logic [CFG_IDX_W-1:0] gain_regs [4];
    logic [GAIN_W-1:0] g;
    tracker = new();
    gain_regs = '{REG_POSITION_KP, REG_POSITION_KI, REG_SPEED_KP, REG_SPEED_KI};
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_tick(tick_of('0, '0, '0));
    send_tick(tick_of(Q_MAX, Q_MIN, Q_MIN));
    send_tick(tick_of(Q_MIN, Q_MAX, Q_MAX));
    send_tick(tick_of(32'd1, '0, '0));
    send_tick(tick_of('0, 32'd1, '0));
    send_tick(tick_of(32'sd327680, '0, -32'sd196608));
    send_tick(tick_of('0, '0, Q_MIN));
    send_tick(tick_of('1, '0, 32'd1));
    wait_drained();
    write_gain(REG_POSITION_KP, 32'h0180_0000);
    write_gain(REG_POSITION_KI, 32'h0010_0000);
    write_gain(REG_SPEED_KP, '1);
    write_gain(REG_SPEED_KI, '1);
    write_gain(8'hFF, 32'h1234_5678);
    cfg_valid <= 1'b0;
    repeat (4) send_tick(tick_of(Q_MAX, Q_MIN, Q_MIN));
    repeat (4) send_tick(tick_of(Q_MIN, Q_MAX, Q_MAX));
    send_tick(tick_of(-32'sd3, '0, '0));
    send_tick(tick_of('0, 32'd3, Q_MAX));
    send_tick(tick_of(32'sd655360, '0, 32'sd655360));
    send_tick(tick_of(32'd1, '0, '1));
    send_tick(tick_of(Q_MAX, Q_MAX, Q_MIN));
    send_tick(tick_of(Q_MIN, Q_MIN, Q_MAX));

    for (int ph = 0; ph < 10; ph++) begin
      wait_drained();
      for (int r = 0; r < 4; r++) begin
        case (ph)
          0: g = '1;
          1: g = '0;
          default: g = rand_gain();
        endcase
        write_gain(gain_regs[r], g);
      end
      if ($urandom_range(0, 1))
        write_gain(CFG_IDX_W'(REG_SPEED_KI + 1 + $urandom_range(0, 251)), $urandom);
      cfg_valid <= 1'b0;
      for (int n = 0; n < 113; n++) begin
        if (ph == 6 && n == 50) wait_drained();
        send_tick(random_tick());
      end
    end

    wait_drained();
    repeat (250) @(posedge clk);
    if (tracker.mismatch_count == 0 && tracker.expected_results.size() == 0) begin
      $display("cascaded_position_speed_pi test passed");
    end else begin
      $display("cascaded_position_speed_pi test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/cpsp_pkg.sv
src/cpsp_smul.sv
src/cpsp_cdiv.sv
src/cascaded_position_speed_pi.sv
bench/cascaded_position_speed_pi_tb.sv
